FILE: rtl/assert_macros.svh
// Shared assertion macros for the link monitor checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-gated.
`define SPLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-gated.
`define SPLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/splm_pkg.sv
`default_nettype none

package splm_pkg;

    localparam int NUM_RD     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [31:0] t_rd;
    typedef logic signed [32:0] t_bound;

    localparam t_rd ABSENT = 32'sh8000_0000;

    // Beat kinds.
    localparam logic CMD_PKT  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CO2_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CO2_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LUX_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOIL_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd7;

    // Reset values, 4 fraction bits.
    localparam logic [30:0]        RST_CO2_LOW   = 31'd4800;
    localparam logic [30:0]        RST_CO2_HIGH  = 31'd640000;
    localparam logic signed [31:0] RST_TEMP_LOW  = -32'sd320;
    localparam logic signed [31:0] RST_TEMP_HIGH = 32'sd1120;
    localparam logic [30:0]        RST_HUM_HIGH  = 31'd1680;
    localparam logic [30:0]        RST_LUX_HIGH  = 31'd3200000;
    localparam logic [30:0]        RST_SOIL_HIGH = 31'd1680;
    localparam logic [31:0]        RST_TIMEOUT   = 32'd15000;

    typedef struct packed {
        logic [30:0]        co2_low;
        logic [30:0]        co2_high;
        logic signed [31:0] temp_low;
        logic signed [31:0] temp_high;
        logic [30:0]        hum_high;
        logic [30:0]        lux_high;
        logic [30:0]        soil_high;
        logic [31:0]        online_timeout;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/sensor_packet_link_monitor_core.sv
`default_nettype none
// Channel   Handshake                  Beat contents
// -------   ------------------------   ------------------------------------------
// in        i_in_valid / o_in_stall     cmd, seq, five readings
// out       o_out_valid / i_out_stall   five readings, online, four counters, seen
// cfg       i_cfg_we (no wait)          i_cfg_idx, i_cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; an accepted beat
// passes through the input register, then the state/result register, to o_out_valid.
// The state registers double as the result register: they move only when the
// output register is free, so a stalled result holds without a copy.
// Reset is synchronous, active low; it restores the default bounds, clears
// counters and flags and fills every reading with the absent code.
// o_in_stall rises only while the input register is full and the output is stalled.

module sensor_packet_link_monitor_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [splm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [splm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [7:0]                        i_seq,
    input  logic signed [31:0]                i_co2_in,
    input  logic signed [31:0]                i_temp_in,
    input  logic signed [31:0]                i_hum_in,
    input  logic signed [31:0]                i_lux_in,
    input  logic signed [31:0]                i_soil_in,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_co2_out,
    output logic signed [31:0]                o_temp_out,
    output logic signed [31:0]                o_hum_out,
    output logic signed [31:0]                o_lux_out,
    output logic signed [31:0]                o_soil_out,
    output logic                              o_online,
    output logic [31:0]                       o_accepted_count,
    output logic [31:0]                       o_dup_count,
    output logic [31:0]                       o_lost_count,
    output logic [31:0]                       o_rejected_count,
    output logic                              o_seen_lux,
    output logic                              o_seen_soil
);
    import splm_pkg::*;

    t_cfg cfg;

    // Input register.
    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_seq;
    t_rd         r_rd [NUM_RD];

    // Link state; also the result beat.
    logic        r_out_valid, n_out_valid;
    logic        r_have,      n_have;
    logic [7:0]  r_last,      n_last;
    logic        r_ever,      n_ever;
    logic [31:0] r_age,       n_age;
    logic        r_online,    n_online;
    t_rd         r_store [NUM_RD];
    t_rd         n_store [NUM_RD];
    logic [31:0] r_acc,  n_acc;
    logic [31:0] r_dup,  n_dup;
    logic [31:0] r_lost, n_lost;
    logic [31:0] r_rej,  n_rej;
    logic        r_seen_lux,  n_seen_lux;
    logic        r_seen_soil, n_seen_soil;

    logic        out_free;
    logic        adv;
    logic        is_dup;
    logic [7:0]  gap;
    logic [31:0] lost_inc;
    t_bound      lo [NUM_RD];
    t_bound      hi [NUM_RD];
    t_rd         chk_val [NUM_RD];
    logic [NUM_RD-1:0] chk_bad;
    logic        pkt_bad;

    splm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Handshake: advance when the result slot is empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload needs no reset: load on accepted beat only.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd   <= i_cmd;
            r_seq   <= i_seq;
            r_rd[0] <= i_co2_in;
            r_rd[1] <= i_temp_in;
            r_rd[2] <= i_hum_in;
            r_rd[3] <= i_lux_in;
            r_rd[4] <= i_soil_in;
        end
    end

    // Bounds per channel; humidity, light and soil have a fixed zero floor.
    assign lo[0] = {2'b00, cfg.co2_low};
    assign hi[0] = {2'b00, cfg.co2_high};
    assign lo[1] = {cfg.temp_low[31], cfg.temp_low};
    assign hi[1] = {cfg.temp_high[31], cfg.temp_high};
    assign lo[2] = '0;
    assign hi[2] = {2'b00, cfg.hum_high};
    assign lo[3] = '0;
    assign hi[3] = {2'b00, cfg.lux_high};
    assign lo[4] = '0;
    assign hi[4] = {2'b00, cfg.soil_high};

    for (genvar g = 0; g < NUM_RD; g++) begin : g_rng
        splm_range u_range (
            .i_val (r_rd[g]),
            .i_lo  (lo[g]),
            .i_hi  (hi[g]),
            .o_val (chk_val[g]),
            .o_bad (chk_bad[g])
        );
    end

    // Only CO2, temperature and humidity can reject a packet.
    assign pkt_bad = chk_bad[0] | chk_bad[1] | chk_bad[2];

    assign is_dup   = r_have && (r_seq == r_last);
    assign gap      = r_seq - r_last;
    assign lost_inc = (r_have && (gap > 8'd1)) ? {24'd0, gap - 8'd1} : 32'd0;

    always_comb begin
        n_have      = r_have;
        n_last      = r_last;
        n_ever      = r_ever;
        n_age       = r_age;
        n_store     = r_store;
        n_acc       = r_acc;
        n_dup       = r_dup;
        n_lost      = r_lost;
        n_rej       = r_rej;
        n_seen_lux  = r_seen_lux;
        n_seen_soil = r_seen_soil;
        if (adv) begin
            if (r_cmd == CMD_TICK) begin
                // Saturate the age instead of wrapping.
                if (r_age != '1) begin
                    n_age = r_age + 32'd1;
                end
            end else if (is_dup) begin
                n_dup = r_dup + 32'd1;
            end else begin
                n_have  = 1'b1;
                n_last  = r_seq;
                n_store = chk_val;
                n_lost  = r_lost + lost_inc;
                if (pkt_bad) begin
                    n_rej = r_rej + 32'd1;
                end
                if (chk_val[3] != ABSENT) begin
                    n_seen_lux = 1'b1;
                end
                if (chk_val[4] != ABSENT) begin
                    n_seen_soil = 1'b1;
                end
                n_ever = 1'b1;
                n_age  = '0;
                n_acc  = r_acc + 32'd1;
            end
        end
        n_online = n_ever && (n_age < cfg.online_timeout);
    end

    always_comb begin
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_last      <= '0;
            r_ever      <= 1'b0;
            r_age       <= '0;
            r_online    <= 1'b0;
            for (int i = 0; i < NUM_RD; i++) begin
                r_store[i] <= ABSENT;
            end
            r_acc       <= '0;
            r_dup       <= '0;
            r_lost      <= '0;
            r_rej       <= '0;
            r_seen_lux  <= 1'b0;
            r_seen_soil <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_last      <= n_last;
            r_ever      <= n_ever;
            r_age       <= n_age;
            // Hold online with the rest of the beat while stalled.
            if (adv) begin
                r_online <= n_online;
            end
            r_store     <= n_store;
            r_acc       <= n_acc;
            r_dup       <= n_dup;
            r_lost      <= n_lost;
            r_rej       <= n_rej;
            r_seen_lux  <= n_seen_lux;
            r_seen_soil <= n_seen_soil;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_co2_out        = r_store[0];
    assign o_temp_out       = r_store[1];
    assign o_hum_out        = r_store[2];
    assign o_lux_out        = r_store[3];
    assign o_soil_out       = r_store[4];
    assign o_online         = r_online;
    assign o_accepted_count = r_acc;
    assign o_dup_count      = r_dup;
    assign o_lost_count     = r_lost;
    assign o_rejected_count = r_rej;
    assign o_seen_lux       = r_seen_lux;
    assign o_seen_soil      = r_seen_soil;

endmodule

`default_nettype wire

FILE: rtl/splm_cfg.sv
`default_nettype none

module splm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [splm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [splm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output splm_pkg::t_cfg                    o_cfg
);
    import splm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CO2_LOW:   n_cfg.co2_low        = i_cfg_wdata[30:0];
                REG_CO2_HIGH:  n_cfg.co2_high       = i_cfg_wdata[30:0];
                REG_TEMP_LOW:  n_cfg.temp_low       = i_cfg_wdata;
                REG_TEMP_HIGH: n_cfg.temp_high      = i_cfg_wdata;
                REG_HUM_HIGH:  n_cfg.hum_high       = i_cfg_wdata[30:0];
                REG_LUX_HIGH:  n_cfg.lux_high       = i_cfg_wdata[30:0];
                REG_SOIL_HIGH: n_cfg.soil_high      = i_cfg_wdata[30:0];
                REG_TIMEOUT:   n_cfg.online_timeout = i_cfg_wdata;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.co2_low        <= RST_CO2_LOW;
            r_cfg.co2_high       <= RST_CO2_HIGH;
            r_cfg.temp_low       <= RST_TEMP_LOW;
            r_cfg.temp_high      <= RST_TEMP_HIGH;
            r_cfg.hum_high       <= RST_HUM_HIGH;
            r_cfg.lux_high       <= RST_LUX_HIGH;
            r_cfg.soil_high      <= RST_SOIL_HIGH;
            r_cfg.online_timeout <= RST_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/splm_range.sv
`default_nettype none

module splm_range (
    input  splm_pkg::t_rd    i_val,
    input  splm_pkg::t_bound i_lo,
    input  splm_pkg::t_bound i_hi,
    output splm_pkg::t_rd    o_val,
    output logic             o_bad
);
    import splm_pkg::*;

    t_bound val_x;
    logic   in_rng;

    // Inclusive window; the absent code may pass if the bounds allow it.
    assign val_x  = {i_val[31], i_val};
    assign in_rng = (val_x >= i_lo) && (val_x <= i_hi);
    assign o_val  = in_rng ? i_val : ABSENT;
    assign o_bad  = !in_rng && (i_val != ABSENT);

endmodule

`default_nettype wire

FILE: rtl/splm_sva.sv
`default_nettype none
`include "assert_macros.svh"

module splm_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_accepted_count,
    input logic [31:0] o_dup_count,
    input logic signed [31:0] o_co2_out,
    input logic        o_seen_lux
);

    // A stalled result beat holds.
    `SPLM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_accepted_count) && $stable(o_co2_out), "stalled beat changed")

    // Accepted count moves by at most one per cycle.
    `SPLM_ASSERT_NXT(a_acc_step, i_clk, i_rst_n, 1'b1, (o_accepted_count == $past(o_accepted_count)) || (o_accepted_count == $past(o_accepted_count) + 32'd1), "accepted count jumped")

    // A packet is either a duplicate or accepted, never both.
    `SPLM_ASSERT_NXT(a_dup_xor_acc, i_clk, i_rst_n, 1'b1, (o_accepted_count == $past(o_accepted_count)) || (o_dup_count == $past(o_dup_count)), "duplicate and accept in one cycle")

    // Light presence is sticky.
    `SPLM_ASSERT_NXT(a_seen_lux_sticky, i_clk, i_rst_n, o_seen_lux, o_seen_lux, "seen_lux cleared")

endmodule

bind sensor_packet_link_monitor_core splm_sva u_sva (.*);

`default_nettype wire
